FILE: design/tksd_pkg.sv
// ----------------------------------------------------------------------------
// tksd_pkg: shared types and constants
// Field widths, the pattern word layout and its unpacking for the timed key
// sequence detector.
// ----------------------------------------------------------------------------
package tksd_pkg;

  localparam int KEY_W      = 8;
  localparam int TIME_W     = 32;
  localparam int PIDX_W     = 3;
  localparam int PAT_KEYS   = 6;
  localparam int LEN_W      = 3;
  localparam int WIN_W      = 13;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  localparam int LEN_LSB = PAT_KEYS * KEY_W;
  localparam int WIN_LSB = LEN_LSB + LEN_W;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [TIME_W-1:0] tstamp_t;
  typedef logic [WIN_W-1:0]  win_t;

  typedef struct packed {
    win_t                      win;
    logic [LEN_W-1:0]          len;
    key_t [PAT_KEYS-1:0]       keys;
  } pattern_t;

  function automatic pattern_t unpack_pattern(input logic [CFG_DATA_W-1:0] w);
    pattern_t p;
    p.keys = w[LEN_LSB-1:0];
    p.len  = w[WIN_LSB-1:LEN_LSB];
    p.win  = w[CFG_DATA_W-1:WIN_LSB];
    return p;
  endfunction

endpackage

FILE: design/tksd_in_if.sv
// ----------------------------------------------------------------------------
// tksd_in_if: key press channel
// Valid/ready channel carrying one key press word: key code and timestamp.
// ----------------------------------------------------------------------------
interface tksd_in_if;
  import tksd_pkg::*;

  logic    valid;
  logic    ready;
  key_t    key_code;
  tstamp_t time_ms;

  modport source (output valid, output key_code, output time_ms, input ready);
  modport sink   (input valid, input key_code, input time_ms, output ready);
endinterface

FILE: design/tksd_out_if.sv
// ----------------------------------------------------------------------------
// tksd_out_if: match result channel
// Valid/ready channel carrying one result word per key press.
// ----------------------------------------------------------------------------
interface tksd_out_if;
  import tksd_pkg::*;

  logic              valid;
  logic              ready;
  logic              matched;
  logic [PIDX_W-1:0] pattern_index;

  modport source (output valid, output matched, output pattern_index, input ready);
  modport sink   (input valid, input matched, input pattern_index, output ready);
endinterface

FILE: design/tksd_match.sv
// ----------------------------------------------------------------------------
// tksd_match: single pattern comparator
// Compares one pattern against the compacted history, newest entry first,
// checking keys and ages over the pattern length.
// ----------------------------------------------------------------------------
module tksd_match #(
  parameter int HISTORY_DEPTH = 6,
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1)
) (
  input  tksd_pkg::pattern_t                        pat,
  input  tksd_pkg::key_t [HISTORY_DEPTH-1:0]        keys,
  input  tksd_pkg::win_t [HISTORY_DEPTH-1:0]        ages,
  input  logic [CNT_W-1:0]                          count,
  output logic                                      hit
);
  import tksd_pkg::*;

  // Entry k from the newest must equal pattern key len-1-k. Kept entries
  // never age past the cap, so the raw window compares as the capped one.
  always_comb begin
    int               kk;
    logic [LEN_W-1:0] sel;
    hit = (pat.len != '0) && (int'(pat.len) <= PAT_KEYS) &&
          (int'(pat.len) <= int'(count));
    for (int k = 0; k < PAT_KEYS; k++) begin
      kk  = (k < HISTORY_DEPTH) ? k : 0;
      sel = pat.len - LEN_W'(k) - LEN_W'(1);
      if (hit && (k < int'(pat.len))) begin
        if (k >= HISTORY_DEPTH) begin
          hit = 1'b0;
        end else if (keys[kk] != pat.keys[sel] || ages[kk] > pat.win) begin
          hit = 1'b0;
        end
      end
    end
  end

endmodule

FILE: design/timed_key_sequence_detector.sv
// ----------------------------------------------------------------------------
// timed_key_sequence_detector: timed multi-pattern key sequence detector
// Takes one key press word (key code and millisecond timestamp) per cycle
// unless the output stalls, keeps the newest HISTORY_DEPTH presses no older
// than MAX_WINDOW_MS, and returns one result word per press: matched and the
// index of the lowest pattern whose keys end the history within its window.
// A match clears the history. Words pass an input register, then the history
// update and result register, in one pass of compaction and NUM_PATTERNS
// parallel comparators. The user must write pattern registers via the cfg
// port only while no word is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module timed_key_sequence_detector #(
  parameter int HISTORY_DEPTH = 6,
  parameter int NUM_PATTERNS  = 6,
  parameter int MAX_WINDOW_MS = 5000
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  tksd_in_if.sink                              in_ch,
  tksd_out_if.source                           out_ch,
  input  logic                                 cfg_wr_en,
  input  logic [tksd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tksd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tksd_pkg::*;

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

  logic [CFG_DATA_W-1:0]      pat_word_r [NUM_PATTERNS];

  logic                       s1_valid_r;
  key_t                       s1_key_r;
  tstamp_t                    s1_time_r;

  key_t    [HISTORY_DEPTH-1:0] hist_key_r;
  tstamp_t [HISTORY_DEPTH-1:0] hist_time_r;
  logic [CNT_W-1:0]            hist_cnt_r;

  logic                       out_valid_r;
  logic                       out_matched_r;
  logic [PIDX_W-1:0]          out_index_r;

  logic                       fire;

  key_t    [HISTORY_DEPTH-1:0] e_key;
  tstamp_t [HISTORY_DEPTH-1:0] e_time;
  logic    [HISTORY_DEPTH-1:0] keep;
  win_t    [HISTORY_DEPTH-1:0] e_age;
  logic [CNT_W-1:0]            pre [HISTORY_DEPTH];

  key_t    [HISTORY_DEPTH-1:0] c_key;
  tstamp_t [HISTORY_DEPTH-1:0] c_time;
  win_t    [HISTORY_DEPTH-1:0] c_age;
  logic [CNT_W-1:0]            kept_cnt;

  logic [NUM_PATTERNS-1:0]    hit_vec;
  logic                       hit;
  logic [PIDX_W-1:0]          which;

  // Handshake
  assign fire         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || fire;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.matched       = out_matched_r;
  assign out_ch.pattern_index = out_index_r;

  // Append the new press at the newest end; the oldest word falls off.
  always_comb begin
    tstamp_t age;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      if (k == 0) begin
        e_key[k]  = s1_key_r;
        e_time[k] = s1_time_r;
      end else begin
        e_key[k]  = hist_key_r[k-1];
        e_time[k] = hist_time_r[k-1];
      end
      age      = s1_time_r - e_time[k];
      keep[k]  = ((k == 0) || (k - 1 < int'(hist_cnt_r))) &&
                 (age <= TIME_W'(MAX_WINDOW_MS));
      e_age[k] = age[WIN_W-1:0];
    end
  end

  // Compact the kept words, preserving order, newest first.
  always_comb begin
    logic [HISTORY_DEPTH-1:0] lowmask;
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      lowmask = HISTORY_DEPTH'((1 << k) - 1);
      pre[k]  = CNT_W'($countones(keep & lowmask));
    end
    kept_cnt = CNT_W'($countones(keep));
    for (int s = 0; s < HISTORY_DEPTH; s++) begin
      c_key[s]  = '0;
      c_time[s] = '0;
      c_age[s]  = '0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        if (keep[k] && pre[k] == CNT_W'(s)) begin
          c_key[s]  = e_key[k];
          c_time[s] = e_time[k];
          c_age[s]  = e_age[k];
        end
      end
    end
  end

  for (genvar p = 0; p < NUM_PATTERNS; p++) begin : g_match
    tksd_match #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_match (
      .pat   (unpack_pattern(pat_word_r[p])),
      .keys  (c_key),
      .ages  (c_age),
      .count (kept_cnt),
      .hit   (hit_vec[p])
    );
  end

  // Lowest index wins
  always_comb begin
    hit   = |hit_vec;
    which = '0;
    for (int p = NUM_PATTERNS - 1; p >= 0; p--) begin
      if (hit_vec[p]) begin
        which = PIDX_W'(p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hist_cnt_r  <= '0;
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        pat_word_r[p] <= '0;
      end
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        hist_cnt_r  <= hit ? '0 : kept_cnt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      // Writes to indexes past the last pattern drop silently.
      for (int p = 0; p < NUM_PATTERNS; p++) begin
        if (cfg_wr_en && cfg_index == CFG_IDX_W'(p)) begin
          pat_word_r[p] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_key_r  <= in_ch.key_code;
      s1_time_r <= in_ch.time_ms;
    end
    if (fire) begin
      hist_key_r    <= c_key;
      hist_time_r   <= c_time;
      out_matched_r <= hit;
      out_index_r   <= which;
    end
  end

`ifndef SYNTHESIS
  a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && hit |=> hist_cnt_r == '0)
    else $error("history not cleared after a match");

  a_fire_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed word produced no result");

  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_matched_r |-> out_index_r == '0)
    else $error("nonzero index without a match");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hist_cnt_r <= CNT_W'(HISTORY_DEPTH))
    else $error("history count beyond depth");
`endif

endmodule
